[rtl/eqpx_pkg.sv]
// shared types and constants for the equal-power crossfader
package eqpx_pkg;

    // fixed field widths
    localparam int SAMPLE_BITS = 16;
    localparam int CFG_W       = 16;

    // gain format: unsigned q1.15, 0 .. 32768
    localparam int GAIN_W    = 16;
    localparam int GAIN_FRAC = 15;
    localparam int ONE_Q15   = 32768;

    // mix accumulator: two products of sample by gain plus headroom
    localparam int ACC_W = SAMPLE_BITS + GAIN_W + 2;

    // default table size and fade length after reset
    localparam int GAIN_TABLE_SIZE_DEF = 256;
    localparam logic [CFG_W-1:0] FADE_LENGTH_RESET = 16'd22050;

    // pi/2 in q30
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] current_sample;
        logic signed [SAMPLE_BITS-1:0] next_sample;
        logic                          start_fade;
    } in_beat_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] out_sample;
        logic                          fading;
        logic                          fade_done;
    } out_beat_t;

endpackage

[rtl/eqpx_div.sv]
// radix-2 restoring divider, one quotient bit per cycle
module eqpx_div #(
    parameter int NUM_W = 26,
    parameter int DEN_W = 17,
    parameter int QUO_W = 9
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [QUO_W-1:0] quot
);

    localparam int CNT_W = $clog2(QUO_W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [QUO_W-1:0] quo_reg, quo_next;
    logic [DEN_W:0]   trial;
    logic             fits;

    always_comb begin
        trial     = {rem_reg, quo_reg[QUO_W-1]};
        fits      = (trial >= {1'b0, den_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        if (start) begin
            // quotient fits in QUO_W bits, so the upper part is already below den
            rem_next  = DEN_W'(num >> QUO_W);
            quo_next  = num[QUO_W-1:0];
            den_next  = den;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
            quo_next = {quo_reg[QUO_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(QUO_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule

[rtl/eqpx_gain_rom.sv]
// quarter-sine gain table, built at elaboration, registered read
module eqpx_gain_rom #(
    parameter int GAIN_TABLE_SIZE = eqpx_pkg::GAIN_TABLE_SIZE_DEF
) (
    input  logic                                   aclk,
    input  logic [$clog2(GAIN_TABLE_SIZE+1)-1:0]   addr,
    output logic [eqpx_pkg::GAIN_W-1:0]            data
);

    import eqpx_pkg::*;

    localparam int TAYLOR_TERMS = 7;
    localparam int ROM_W        = (GAIN_TABLE_SIZE + 1) * GAIN_W;

    // sin(i*pi/(2*size)) by a truncated q30 taylor series, rounded to q15
    function automatic logic [GAIN_W-1:0] quarter_sine(input int unsigned idx);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        g;
        int                 k;
        x    = (64'(idx) * HALF_PI_Q30 + 64'(GAIN_TABLE_SIZE / 2)) / 64'(GAIN_TABLE_SIZE);
        x2   = (x * x + (64'd1 << 29)) >> 30;
        term = x;
        sum  = $signed(x);
        for (k = 1; k <= TAYLOR_TERMS; k++) begin
            term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
            if (k[0]) begin
                sum = sum - $signed(term);
            end else begin
                sum = sum + $signed(term);
            end
        end
        if (sum <= 0) begin
            g = '0;
        end else begin
            g = (64'(sum) + (64'd1 << 14)) >> 15;
            if (g > 64'(ONE_Q15)) begin
                g = 64'(ONE_Q15);
            end
        end
        return GAIN_W'(g);
    endfunction

    function automatic logic [ROM_W-1:0] build_rom();
        logic [ROM_W-1:0] rom;
        int               i;
        rom = '0;
        for (i = 0; i <= GAIN_TABLE_SIZE; i++) begin
            rom[i*GAIN_W +: GAIN_W] = quarter_sine(i);
        end
        return rom;
    endfunction

    localparam logic [ROM_W-1:0] GAIN_ROM = build_rom();

    logic [GAIN_W-1:0] data_reg;

    always_ff @(posedge aclk) begin
        data_reg <= GAIN_ROM[GAIN_W*addr +: GAIN_W];
    end

    assign data = data_reg;

endmodule

[rtl/eqpx_mac.sv]
// bit-serial dual multiply-accumulate: cur*gain_cos + nxt*gain_sin, gain msb first
module eqpx_mac (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  logic                                       start,
    input  logic signed [eqpx_pkg::SAMPLE_BITS-1:0]    cur,
    input  logic signed [eqpx_pkg::SAMPLE_BITS-1:0]    nxt,
    input  logic        [eqpx_pkg::GAIN_W-1:0]         gain_cos,
    input  logic        [eqpx_pkg::GAIN_W-1:0]         gain_sin,
    output logic                                       done,
    output logic signed [eqpx_pkg::ACC_W-1:0]          acc
);

    import eqpx_pkg::*;

    localparam int CNT_W = $clog2(GAIN_W);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic signed [ACC_W-1:0]       acc_reg, acc_next;
    logic [GAIN_W-1:0]             gc_sh_reg, gc_sh_next;
    logic [GAIN_W-1:0]             gs_sh_reg, gs_sh_next;
    logic signed [SAMPLE_BITS-1:0] cur_reg, cur_next;
    logic signed [SAMPLE_BITS-1:0] nxt_reg, nxt_next;
    logic signed [ACC_W-1:0]       add_cur;
    logic signed [ACC_W-1:0]       add_nxt;

    always_comb begin
        add_cur    = gc_sh_reg[GAIN_W-1] ? ACC_W'(cur_reg) : '0;
        add_nxt    = gs_sh_reg[GAIN_W-1] ? ACC_W'(nxt_reg) : '0;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        gc_sh_next = gc_sh_reg;
        gs_sh_next = gs_sh_reg;
        cur_next   = cur_reg;
        nxt_next   = nxt_reg;
        if (start) begin
            acc_next   = '0;
            gc_sh_next = gain_cos;
            gs_sh_next = gain_sin;
            cur_next   = cur;
            nxt_next   = nxt;
            cnt_next   = '0;
            busy_next  = 1'b1;
        end else if (busy_reg) begin
            acc_next   = (acc_reg <<< 1) + add_cur + add_nxt;
            gc_sh_next = {gc_sh_reg[GAIN_W-2:0], 1'b0};
            gs_sh_next = {gs_sh_reg[GAIN_W-2:0], 1'b0};
            cnt_next   = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(GAIN_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg   <= acc_next;
        gc_sh_reg <= gc_sh_next;
        gs_sh_reg <= gs_sh_next;
        cur_reg   <= cur_next;
        nxt_reg   <= nxt_next;
        cnt_reg   <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done = done_reg;
    assign acc  = acc_reg;

endmodule

[rtl/equal_power_crossfader.sv]
// top level of the equal-power crossfader
//
// Equal-power crossfade between two sample streams. Each input beat is one
// output tick and gives exactly one result beat. While no fade runs the
// current sample passes straight through (fading = 0). A beat with start_fade
// set, also one during a running fade, restarts the fade at count zero; for
// fade_length ticks the result is current*cos(r*pi/2) + next*sin(r*pi/2) with
// r = count/fade_length, rounded and saturated to 16 bits, and fade_done marks
// the last mixed tick. fade_length is written through cfg_wr_en/cfg_wr_data
// (a value of 0 acts as 1) and resets to 22050; write it only while the block
// is idle. One beat is in work at a time. A pass-through beat is held in the
// result register in ST_OUT and goes to the output register from there. A
// mixed beat is worked through the states in order: the table index comes
// from a serial divider at one quotient bit per cycle, the two gains are read
// one after the other from the gain table, the mix is a bit-serial multiply
// over the 16 gain bits, and the result is rounded, saturated and handed to
// the output register. The output register holds a finished beat while the
// next input beat is taken; a beat that finds it still full waits for as long
// as the result side stalls.
module equal_power_crossfader #(
    parameter int GAIN_TABLE_SIZE = eqpx_pkg::GAIN_TABLE_SIZE_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input beats
    input  logic                          s_valid,
    output logic                          s_ready,
    input  eqpx_pkg::in_beat_t            s_data,
    // result beats
    output logic                          m_valid,
    input  logic                          m_ready,
    output eqpx_pkg::out_beat_t           m_data,
    // fade length register
    input  logic                          cfg_wr_en,
    input  logic [eqpx_pkg::CFG_W-1:0]    cfg_wr_data
);

    import eqpx_pkg::*;

    // table index width, quotient width of the divider
    localparam int IDX_W = $clog2(GAIN_TABLE_SIZE + 1);
    // count*2*size + len
    localparam int NUM_W = CFG_W + $clog2(2 * GAIN_TABLE_SIZE) + 1;
    // divisor is 2*len
    localparam int DEN_W = CFG_W + 1;
    // width after the q15 shift
    localparam int SR_W  = ACC_W - GAIN_FRAC;

    localparam logic signed [SR_W-1:0] SAT_MAX = SR_W'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [SR_W-1:0] SAT_MIN = -SAT_MAX - SR_W'(1);

    typedef enum logic [2:0] {
        ST_IDLE,    // waiting for an input beat
        ST_DIV,     // serial divide for the table index
        ST_SIN,     // sine gain address out
        ST_COS,     // cosine gain address out, sine gain back
        ST_MSTART,  // cosine gain back, start the mix
        ST_MAC,     // bit-serial mix running
        ST_FIN,     // round, saturate, step the fade
        ST_OUT      // hand the result to the output register
    } state_t;

    state_t                        state_reg, state_next;
    logic [CFG_W-1:0]              fade_len_reg, fade_len_next;
    logic                          active_reg, active_next;
    logic [CFG_W-1:0]              count_reg, count_next;
    logic signed [SAMPLE_BITS-1:0] cur_reg, cur_next;
    logic signed [SAMPLE_BITS-1:0] nxt_reg, nxt_next;
    logic [IDX_W-1:0]              k_reg, k_next;
    logic [GAIN_W-1:0]             gs_reg, gs_next;
    out_beat_t                     res_reg, res_next;
    logic                          m_valid_reg, m_valid_next;
    out_beat_t                     m_data_reg, m_data_next;

    // fade bookkeeping for the beat at the input
    logic [CFG_W-1:0]              len;
    logic                          active_in;
    logic [CFG_W-1:0]              count_in;
    logic                          mix_in;
    logic                          last_tick;

    // divider
    logic                          div_start;
    logic [NUM_W-1:0]              div_num;
    logic [DEN_W-1:0]              div_den;
    logic                          div_done;
    logic [IDX_W-1:0]              div_quot;

    // gain table
    logic [IDX_W-1:0]              rom_addr;
    logic [GAIN_W-1:0]             rom_data;

    // mixer
    logic                          mac_start;
    logic                          mac_done;
    logic signed [ACC_W-1:0]       mac_acc;

    // rounding and saturation
    logic signed [ACC_W-1:0]       acc_rnd;
    logic signed [SR_W-1:0]        acc_q15;
    logic signed [SAMPLE_BITS-1:0] mix_sat;

    // zero length acts as one
    assign len = (fade_len_reg == '0) ? CFG_W'(1) : fade_len_reg;

    always_comb begin
        // a start flag restarts the fade from zero
        active_in = s_data.start_fade ? 1'b1 : active_reg;
        count_in  = s_data.start_fade ? '0 : count_reg;
        // a length shortened below the count ends the fade at once
        mix_in    = active_in && (count_in < len);
        // round(count*size/len) as floor((2*count*size + len) / (2*len))
        div_num   = NUM_W'(count_in) * NUM_W'(2 * GAIN_TABLE_SIZE) + NUM_W'(len);
        div_den   = {len, 1'b0};
        last_tick = (({1'b0, count_reg} + DEN_W'(1)) >= {1'b0, len});
    end

    always_comb begin
        acc_rnd = mac_acc + ACC_W'(ONE_Q15 / 2);
        // arithmetic shift gives floor division by 2^15
        acc_q15 = $signed(acc_rnd[ACC_W-1:GAIN_FRAC]);
        if (acc_q15 > SAT_MAX) begin
            mix_sat = SAMPLE_BITS'(SAT_MAX);
        end else if (acc_q15 < SAT_MIN) begin
            mix_sat = SAMPLE_BITS'(SAT_MIN);
        end else begin
            mix_sat = acc_q15[SAMPLE_BITS-1:0];
        end
    end

    // sine gain at k, cosine gain mirrored at size-k
    always_comb begin
        case (state_reg)
            ST_COS:  rom_addr = IDX_W'(GAIN_TABLE_SIZE) - k_reg;
            default: rom_addr = k_reg;
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        fade_len_next = fade_len_reg;
        active_next   = active_reg;
        count_next    = count_reg;
        cur_next      = cur_reg;
        nxt_next      = nxt_reg;
        k_next        = k_reg;
        gs_next       = gs_reg;
        res_next      = res_reg;
        div_start     = 1'b0;
        mac_start     = 1'b0;
        // output register drains on its own handshake
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;

        if (cfg_wr_en) begin
            fade_len_next = cfg_wr_data;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cur_next    = s_data.current_sample;
                    nxt_next    = s_data.next_sample;
                    count_next  = count_in;
                    active_next = mix_in;
                    if (mix_in) begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end else begin
                        // pass-through tick
                        res_next.out_sample = s_data.current_sample;
                        res_next.fading     = 1'b0;
                        res_next.fade_done  = 1'b0;
                        state_next          = ST_OUT;
                    end
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    k_next     = (div_quot > IDX_W'(GAIN_TABLE_SIZE)) ?
                                 IDX_W'(GAIN_TABLE_SIZE) : div_quot;
                    state_next = ST_SIN;
                end
            end
            ST_SIN: begin
                state_next = ST_COS;
            end
            ST_COS: begin
                gs_next    = rom_data;
                state_next = ST_MSTART;
            end
            ST_MSTART: begin
                mac_start  = 1'b1;
                state_next = ST_MAC;
            end
            ST_MAC: begin
                if (mac_done) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                res_next.out_sample = mix_sat;
                res_next.fading     = 1'b1;
                res_next.fade_done  = last_tick;
                count_next          = count_reg + 1'b1;
                if (last_tick) begin
                    active_next = 1'b0;
                end
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        cur_reg    <= cur_next;
        nxt_reg    <= nxt_next;
        k_reg      <= k_next;
        gs_reg     <= gs_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            fade_len_reg <= FADE_LENGTH_RESET;
            active_reg   <= 1'b0;
            count_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            fade_len_reg <= fade_len_next;
            active_reg   <= active_next;
            count_reg    <= count_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // ready only between beats
    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    eqpx_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W),
        .QUO_W (IDX_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quot    (div_quot)
    );

    eqpx_gain_rom #(
        .GAIN_TABLE_SIZE (GAIN_TABLE_SIZE)
    ) u_rom (
        .aclk (aclk),
        .addr (rom_addr),
        .data (rom_data)
    );

    eqpx_mac u_mac (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (mac_start),
        .cur      (cur_reg),
        .nxt      (nxt_reg),
        .gain_cos (rom_data),
        .gain_sin (gs_reg),
        .done     (mac_done),
        .acc      (mac_acc)
    );

endmodule

[rtl/eqpx_checker.sv]
// port-level checks for the crossfader, bound to the top level
module eqpx_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input eqpx_pkg::out_beat_t m_data
);

    // beats taken in but not yet delivered
    logic [1:0] pending_reg;
    logic [1:0] pending_next;

    assign pending_next = pending_reg + 2'(s_valid && s_ready) - 2'(m_valid && m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else begin
            pending_reg <= pending_next;
        end
    end

    // no result beat without an input beat behind it
    a_no_invented: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready) |-> (pending_reg != 2'd0))
        else $error("result beat with no input beat outstanding");

    // one beat in work and one in the output register at most
    a_no_third: assert property (@(posedge aclk) disable iff (!aresetn)
        (pending_reg == 2'd2) |-> !s_ready)
        else $error("input taken with two beats outstanding");

    // the last-tick flag only rides on a mixed beat
    a_done_mixed: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.fade_done) |-> m_data.fading)
        else $error("fade_done on a pass-through beat");

    // a stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("result beat changed while stalled");

    // nothing offered right after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind equal_power_crossfader eqpx_checker u_eqpx_checker (.*);

[tb/sv/tb_top.sv]
// self-checking testbench for the equal-power crossfader: directed and random beats
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import eqpx_pkg::*;

    localparam int TABLE_SIZE = GAIN_TABLE_SIZE_DEF;
    localparam int SAMPLE_MAX = 32767;
    localparam int SAMPLE_MIN = -32768;
    localparam int LONG_HOLD  = 300;   // cycles of receiver back-pressure
    localparam int REPORT_MAX = 10;

    // clock, reset and block ports
    logic        aclk;
    logic        aresetn     = 1'b0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    in_beat_t    s_data      = '0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    out_beat_t   m_data;
    logic        cfg_wr_en   = 1'b0;
    logic [CFG_W-1:0] cfg_wr_data = '0;

    equal_power_crossfader i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // crossfade predictor: own copy of the fade state and fade length
    // ------------------------------------------------------------------
    int          gain_q15 [0:TABLE_SIZE];
    bit          pred_fading;
    logic [15:0] pred_count;
    logic [15:0] pred_length;

    // one quarter-sine gain in q1.15, integer taylor series in q30
    function automatic int quarter_sine_q15(int i);
        longint unsigned iu, x, x2, term, g;
        longint          sum;
        iu = 64'(i);
        x  = (iu * HALF_PI_Q30 + 64'(TABLE_SIZE / 2)) / 64'(TABLE_SIZE);
        x2 = (x * x + (64'd1 << 29)) >> 30;
        term = x;
        sum  = longint'(x);
        for (int k = 1; k <= 7; k++) begin
            // each term truncated, alternating sign
            term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum <= 0) return 0;
        g = 64'(sum);
        g = (g + (64'd1 << 14)) >> 15;
        if (g > 64'(ONE_Q15)) g = 64'(ONE_Q15);
        return int'(g);
    endfunction

    // advance the fade state by one tick and return the expected result beat
    function automatic out_beat_t crossfade_predict(in_beat_t b);
        out_beat_t       r;
        longint unsigned len_q, pos_q, idx;
        longint          cur, nxt, gs, gc, acc, q;
        len_q = (pred_length == 16'd0) ? 64'd1 : 64'(pred_length);
        r     = '0;
        if (b.start_fade) begin
            pred_fading = 1'b1;
            pred_count  = '0;
        end
        pos_q = 64'(pred_count);
        // length shortened below the running count ends the fade at once
        if (pred_fading && pos_q >= len_q) pred_fading = 1'b0;
        if (!pred_fading) begin
            r.out_sample = b.current_sample;
            return r;
        end
        // table index rounded half up
        idx = (pos_q * 64'(TABLE_SIZE) * 64'd2 + len_q) / (64'd2 * len_q);
        if (idx > 64'(TABLE_SIZE)) idx = 64'(TABLE_SIZE);
        gs  = longint'(gain_q15[idx]);
        gc  = longint'(gain_q15[64'(TABLE_SIZE) - idx]);
        cur = longint'(b.current_sample);
        nxt = longint'(b.next_sample);
        acc = cur * gc + nxt * gs + longint'(ONE_Q15 / 2);
        q   = acc >>> GAIN_FRAC;   // floor division by 2^15
        if (q > longint'(SAMPLE_MAX)) q = longint'(SAMPLE_MAX);
        if (q < longint'(SAMPLE_MIN)) q = longint'(SAMPLE_MIN);
        r.out_sample = q[SAMPLE_BITS-1:0];
        r.fading     = 1'b1;
        if (pos_q + 64'd1 >= len_q) begin
            r.fade_done = 1'b1;
            pred_fading = 1'b0;
        end
        pred_count = pred_count + 16'd1;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // queues and counters shared by the processes
    // ------------------------------------------------------------------
    in_beat_t  pending_beats [$];
    out_beat_t expected_mix  [$];
    int        mismatch_count = 0;
    int        beats_in       = 0;

    // ------------------------------------------------------------------
    // driver: bursts of random length with random gaps
    // ------------------------------------------------------------------
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            // beat accepted at this edge: predict its result
            if (s_valid && s_ready) begin
                expected_mix.push_back(crossfade_predict(s_data));
                beats_in++;
            end
            // slot is free: offer the next beat or idle
            if (!s_valid || s_ready) begin
                if (gap_left == 0 && pending_beats.size() > 0) begin
                    s_data  <= pending_beats.pop_front();
                    s_valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 40);
                        // a third of the bursts run back to back with no gap
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    s_valid <= 1'b0;
                    if (gap_left > 0) gap_left--;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: receiver stall pattern, long hold-offs and result checking
    // ------------------------------------------------------------------
    int rx_mode      = 0;
    int mode_left    = 0;
    int hold_left    = 0;
    int next_hold_at = 300;
    int rx_cycle     = 0;
    bit rx_ready;

    task automatic check_result(out_beat_t got);
        out_beat_t want;
        bit        bad;
        if (expected_mix.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
                $display("result beat with nothing expected: out_sample=%0d fading=%0b",
                         got.out_sample, got.fading);
            return;
        end
        want = expected_mix.pop_front();
        bad  = (got.out_sample !== want.out_sample) || (got.fading !== want.fading)
            || (got.fade_done !== want.fade_done);
        if (bad) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX) begin
                $display("mismatch at %0t: out_sample exp %0d got %0d",
                         $realtime, want.out_sample, got.out_sample);
                $display("  fading exp %0b got %0b, fade_done exp %0b got %0b",
                         want.fading, got.fading, want.fade_done, got.fade_done);
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) check_result(m_data);
            rx_cycle++;
            // switch stall pattern now and then
            if (mode_left == 0) begin
                rx_mode   = $urandom_range(0, 3);
                mode_left = $urandom_range(64, 512);
            end else begin
                mode_left--;
            end
            // long hold-off while the sender still has plenty queued
            if (hold_left > 0) begin
                hold_left--;
            end else if (beats_in >= next_hold_at && pending_beats.size() > 40) begin
                hold_left    = LONG_HOLD;
                next_hold_at = next_hold_at + 600;
            end
            case (rx_mode)
                0: begin
                    rx_ready = 1'b1;
                end
                1: begin
                    rx_ready = ($urandom_range(0, 3) != 0);
                end
                2: begin
                    rx_ready = ($urandom_range(0, 3) == 0);
                end
                default: begin
                    rx_ready = rx_cycle[2];
                end
            endcase
            m_ready <= (hold_left > 0) ? 1'b0 : rx_ready;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    task automatic push_beat(logic [15:0] cur, logic [15:0] nxt, logic start);
        in_beat_t b;
        b.current_sample = cur;
        b.next_sample    = nxt;
        b.start_fade     = start;
        pending_beats.push_back(b);
    endtask

    // wait until every queued beat went in and every result came out
    task automatic drain_block();
        while (pending_beats.size() != 0 || s_valid || expected_mix.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_fade_length(logic [15:0] value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        pred_length = value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // biased toward full scale and small values
    function automatic logic [15:0] rand_sample();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'($urandom_range(0, 511)) - 16'd256;
            default: return 16'($urandom);
        endcase
    endfunction

    // mostly plain ticks so fades run to the end, with rare restarts
    task automatic queue_random_phase(int n);
        int  len_eff;
        logic start;
        len_eff = (pred_length == 16'd0) ? 1 : int'(pred_length);
        if (len_eff > 4000) len_eff = 4000;
        for (int i = 0; i < n; i++) begin
            if (i == 0) begin
                start = 1'($urandom_range(0, 1));
            end else if ($urandom_range(0, 31) == 0) begin
                start = 1'b1;   // noise: restart anywhere
            end else begin
                start = ($urandom_range(0, 2 * len_eff + 2) == 0);
            end
            push_beat(rand_sample(), rand_sample(), start);
        end
    endtask

    logic [15:0] phase_len [10];

    initial begin
        for (int i = 0; i <= TABLE_SIZE; i++) gain_q15[i] = quarter_sine_q15(i);
        pred_fading = 1'b0;
        pred_count  = '0;
        pred_length = FADE_LENGTH_RESET;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // idle pass-through at the sample extremes, default length
        push_beat(16'h8000, 16'h7fff, 1'b0);
        push_beat(16'h7fff, 16'h8000, 1'b0);
        push_beat(16'h0000, 16'h0000, 1'b0);
        drain_block();

        // two-tick fades: full gain then mid point saturating both ways
        write_fade_length(16'd2);
        push_beat(16'h7fff, 16'h7fff, 1'b1);
        push_beat(16'h7fff, 16'h7fff, 1'b0);
        push_beat(16'h8000, 16'h8000, 1'b1);
        push_beat(16'h8000, 16'h8000, 1'b0);
        push_beat(16'h04d2, 16'hfc19, 1'b0);
        // restart while a fade runs
        push_beat(16'h1000, 16'hf000, 1'b1);
        push_beat(16'h2000, 16'he000, 1'b1);
        push_beat(16'h3000, 16'hd000, 1'b0);
        drain_block();

        // zero length acts as one tick
        write_fade_length(16'd0);
        push_beat(16'h4000, 16'hc000, 1'b1);
        push_beat(16'h4000, 16'hc000, 1'b0);
        drain_block();

        // longest fade, then shorten it below the running count
        write_fade_length(16'hffff);
        push_beat(16'h7fff, 16'h8000, 1'b1);
        push_beat(16'h8000, 16'h7fff, 1'b0);
        push_beat(16'h0001, 16'hffff, 1'b0);
        push_beat(16'h5555, 16'haaaa, 1'b0);
        drain_block();
        write_fade_length(16'd3);
        push_beat(16'h1234, 16'h4321, 1'b0);
        push_beat(16'h1234, 16'h4321, 1'b1);
        drain_block();

        // random phases over several fade lengths
        phase_len = '{16'd1, 16'd2, 16'd3, 16'd7, 16'($urandom_range(8, 40)),
                      16'($urandom_range(41, 180)), 16'($urandom_range(100, 180)),
                      16'hffff, 16'd0, FADE_LENGTH_RESET};
        foreach (phase_len[p]) begin
            write_fade_length(phase_len[p]);
            queue_random_phase(185);
            drain_block();
        end

        repeat (40) @(posedge aclk);
        if (expected_mix.size() != 0) begin
            $display("%0d result beats never arrived", expected_mix.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // hang guard
    initial begin
        #10_000_000;
        $display("timeout waiting for the crossfader");
        $display("end of test: mismatches");
        $finish;
    end

endmodule
